// File: sv/ucwp_pkg.sv
// Shared types, constants and a helper function for the command word parser.
// No dependencies; every other file of the parser imports this package.
`default_nettype none

package ucwp_pkg;

  localparam int KW_COUNT = 4;
  localparam int KW_BYTES = 6;
  localparam int KW_W     = 48;
  localparam int LEN_W    = 4;
  localparam int IDX_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int NUM_W    = 8;

  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  typedef logic [KW_W-1:0] kw_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FORMAT  = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef struct packed {
    kw_t              word;
    logic [LEN_W-1:0] len;
    logic             too_long;
    logic             spoiled;
    logic             after_space;
    logic             digit_seen;
    logic [NUM_W-1:0] number;
  } msg_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] index;
  } match_t;

  // "LEDON", "LEDOFF", "LCD", "SERVO", first character in the low byte.
  localparam kw_t KW_RESET [KW_COUNT] = '{
    48'h00_4E_4F_44_45_4C,
    48'h46_46_4F_44_45_4C,
    48'h00_00_00_44_43_4C,
    48'h00_4F_56_52_45_53
  };

  // Number of bytes below the first zero byte of a keyword.
  function automatic logic [LEN_W-1:0] kw_length(input kw_t kw);
    logic             done;
    logic [LEN_W-1:0] n;
    done = 1'b0;
    n    = '0;
    for (int i = 0; i < KW_BYTES; i++) begin
      if (!done) begin
        if (kw[8*i +: 8] != 8'h00) begin
          n = n + LEN_W'(1);
        end else begin
          done = 1'b1;
        end
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: sv/ucwp_msg_state.sv
// Message state of the command word parser: collects the word and the number.
// Depends on ucwp_pkg; cleared after every end of message.
`default_nettype none

module ucwp_msg_state #(
  parameter int MAX_WORD = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step_en,
  input  wire logic                          step_func,
  input  wire logic [ucwp_pkg::CHAR_W-1:0]   step_char,
  output ucwp_pkg::msg_t                     msg
);
  import ucwp_pkg::*;

  msg_t msg_r;
  msg_t msg_nxt;

  logic is_letter;
  logic is_digit;
  logic [CHAR_W-1:0] digit_val;

  assign is_letter = (step_char >= CH_UPPER_A) && (step_char <= CH_LOWER_Z);
  assign is_digit  = (step_char >= CH_ZERO) && (step_char <= CH_NINE);
  assign digit_val = step_char - CH_ZERO;

  always_comb begin
    msg_nxt = msg_r;
    if (step_en) begin
      if (step_func) begin
        msg_nxt = '0;
      end else if (!msg_r.after_space) begin
        if (is_letter) begin
          if (msg_r.len < LEN_W'(MAX_WORD)) begin
            for (int b = 0; b < KW_BYTES; b++) begin
              if (msg_r.len == LEN_W'(b)) begin
                msg_nxt.word[8*b +: 8] = step_char;
              end
            end
            msg_nxt.len = msg_r.len + LEN_W'(1);
          end else begin
            msg_nxt.too_long = 1'b1;
          end
        end else if (step_char == CH_SPACE) begin
          msg_nxt.after_space = 1'b1;
        end else begin
          msg_nxt.spoiled = 1'b1;
        end
      end else if (is_digit) begin
        msg_nxt.digit_seen = 1'b1;
        msg_nxt.number = (msg_r.number << 3) + (msg_r.number << 1) + digit_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_r <= '0;
    end else begin
      msg_r <= msg_nxt;
    end
  end

  assign msg = msg_r;

endmodule

`default_nettype wire

// File: sv/ucwp_matcher.sv
// Keyword compare of the command word parser: status and lowest matching index.
// Depends on ucwp_pkg; purely combinational.
`default_nettype none

module ucwp_matcher #(
  parameter int NUM_COMMANDS = 4
) (
  input  wire ucwp_pkg::msg_t   msg,
  input  wire ucwp_pkg::kw_t    kw [ucwp_pkg::KW_COUNT],
  output ucwp_pkg::match_t      result
);
  import ucwp_pkg::*;

  logic                word_ok;
  logic [KW_COUNT-1:0] hit;

  assign word_ok = !msg.spoiled && !msg.too_long && (msg.len != '0);

  always_comb begin
    for (int i = 0; i < KW_COUNT; i++) begin
      hit[i] = word_ok && (i < NUM_COMMANDS) && (kw_length(kw[i]) == msg.len);
      for (int b = 0; b < KW_BYTES; b++) begin
        if ((LEN_W'(b) < msg.len) && (kw[i][8*b +: 8] != msg.word[8*b +: 8])) begin
          hit[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    result.status = ST_UNKNOWN;
    result.index  = '0;
    if (!msg.after_space || !msg.digit_seen) begin
      result.status = ST_FORMAT;
    end else begin
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
        if (hit[i]) begin
          result.status = ST_OK;
          result.index  = IDX_W'(i);
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/uart_command_word_parser.sv
// Command word parser: one request per cycle unless stalled, a character byte or an end mark.
// An end request is held in the input register, and its result in the result register.
// Throughput: one request per cycle; the input only stalls when an end request
// waits in the input register while the held result is stalled.
// Reset (synchronous, rst_n low) loads the default keywords and clears all
// message state at the next rising clock edge.
`default_nettype none

module uart_command_word_parser #(
  parameter int NUM_COMMANDS = 4,
  parameter int MAX_WORD     = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_func,
  input  wire logic [ucwp_pkg::CHAR_W-1:0]   in_char_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_status,
  output logic [ucwp_pkg::IDX_W-1:0]         out_cmd_index,
  output logic [ucwp_pkg::NUM_W-1:0]         out_cmd_value,
  input  wire logic                          cfg_we,
  input  wire logic [ucwp_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [ucwp_pkg::KW_W-1:0]     cfg_data
);
  import ucwp_pkg::*;

  kw_t kw_r [KW_COUNT];

  logic              a_valid_r;
  logic              a_func_r;
  logic [CHAR_W-1:0] a_char_r;
  logic              a_go;
  logic              step_en;
  logic              end_go;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [NUM_W-1:0]  out_value_r;

  msg_t   msg;
  match_t result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_r <= KW_RESET;
    end else if (cfg_we) begin
      kw_r[cfg_index] <= cfg_data;
    end
  end

  assign in_stall = a_valid_r && a_func_r && out_valid_r && out_stall;
  assign a_go     = !in_stall;
  assign step_en  = a_valid_r && a_go;
  assign end_go   = step_en && a_func_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_go) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && in_valid) begin
      a_func_r <= in_func;
      a_char_r <= in_char_byte;
    end
  end

  ucwp_msg_state #(
    .MAX_WORD (MAX_WORD)
  ) u_msg_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .step_func (a_func_r),
    .step_char (a_char_r),
    .msg       (msg)
  );

  ucwp_matcher #(
    .NUM_COMMANDS (NUM_COMMANDS)
  ) u_matcher (
    .msg    (msg),
    .kw     (kw_r),
    .result (result)
  );

  assign out_valid_nxt = end_go || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (end_go) begin
      out_status_r <= result.status;
      out_index_r  <= result.index;
      out_value_r  <= msg.number;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_cmd_index = out_index_r;
  assign out_cmd_value = out_value_r;

  // The message state is empty right after an end request has been processed.
  assert property (@(posedge clk) disable iff (!rst_n)
    end_go |=> (msg.len == '0) && !msg.after_space && !msg.digit_seen && !msg.spoiled
               && !msg.too_long && (msg.number == '0))
    else $error("message state not cleared after end of message");

  // The input stalls only while a held result is itself stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a stalled result");

  // A result that is not ok carries index zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_index_r == '0))
    else $error("nonzero command index on a failed message");

endmodule

`default_nettype wire
